>>> rtl/tes_pkg.sv
// tes_pkg: shared constants and types for the timed event scheduler.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package tes_pkg;

    localparam int SLOTS    = 4;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 31;
    localparam int SLOTID_W = 2;

    localparam logic [TIME_W-1:0] HALF_RANGE = 32'h7fff_ffff;
    localparam logic [TIME_W-1:0] SIGN_BIT   = 32'h8000_0000;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_RUN      = 1'b1;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [TIME_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } tes_ram_req_t;

endpackage

`default_nettype wire

>>> rtl/tes_slot_ram.sv
// tes_slot_ram: deadline table, one write and one registered read per cycle.
// Per-entry valid bits clear at reset; an entry never written reads as zero.
// Depends on tes_pkg.
`default_nettype none

module tes_slot_ram
    import tes_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tes_ram_req_t      req,
    output logic [TIME_W-1:0]      rd_data
);

    logic [TIME_W-1:0] slot_mem_reg [SLOTS];
    logic [SLOTS-1:0]  valid_reg;
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= valid_reg[req.rd_addr] ? slot_mem_reg[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/tes_ctrl.sv
// tes_ctrl: sequencer for schedule and run transactions, min-search over the
// slot table by repeated read passes, and the output register.
// Depends on tes_pkg; drives tes_slot_ram.
`default_nettype none

module tes_ctrl
    import tes_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [SLOTID_W-1:0] slot_id,
    input  wire logic [TIME_W-1:0]   time_value,
    input  wire logic [DELAY_W-1:0]  delay,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     fire_valid,
    output logic [SLOTID_W-1:0]      fired_slot,
    output logic [TIME_W-1:0]        fired_time,
    output logic [TIME_W-1:0]        next_deadline,
    output logic                     last,
    output tes_ram_req_t             ram_req,
    input  wire logic [TIME_W-1:0]   ram_rd_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_FIRE   = 5'b01000,
        ST_FINAL  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  tv_reg, tv_next;
    logic [TIME_W-1:0]  next_due_reg, next_due_next;
    logic [TIME_W-1:0]  best_key_reg, best_key_next;
    logic [TIME_W-1:0]  best_time_reg, best_time_next;
    logic [SLOT_W-1:0]  best_idx_reg, best_idx_next;
    logic               best_found_reg, best_found_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_fire_reg, out_fire_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [TIME_W-1:0]  out_time_reg, out_time_next;
    logic [TIME_W-1:0]  out_nd_reg, out_nd_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               accept;
    logic [TIME_W-1:0]  when;
    logic [TIME_W-1:0]  nd_diff;
    logic               nd_later;
    logic [CNT_W-1:0]   cnt_prev;
    logic [TIME_W-1:0]  key;
    logic               key_better;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign when     = (time_value + {1'b0, delay}) | 32'h0000_0001;
    assign nd_diff  = next_due_reg - when;
    assign nd_later = (nd_diff != '0) && !nd_diff[TIME_W-1];

    assign cnt_prev   = cnt_reg - CNT_W'(1);
    assign key        = (ram_rd_data - tv_reg) ^ SIGN_BIT;
    assign key_better = (ram_rd_data != '0) && (key < best_key_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        tv_next         = tv_reg;
        next_due_next   = next_due_reg;
        best_key_next   = best_key_reg;
        best_time_next  = best_time_reg;
        best_idx_next   = best_idx_reg;
        best_found_next = best_found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_fire_next   = out_fire_reg;
        out_slot_next   = out_slot_reg;
        out_time_next   = out_time_reg;
        out_nd_next     = out_nd_reg;
        out_last_next   = out_last_reg;
        ram_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tv_next         = time_value;
                    cnt_next        = '0;
                    best_key_next   = HALF_RANGE ^ SIGN_BIT;
                    best_found_next = 1'b0;
                    if (cmd == CMD_RUN)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        if (32'(slot_id) < SLOTS)
                        begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = SLOT_W'(slot_id);
                            ram_req.wr_data = when;
                            if (next_due_reg == '0 || nd_later)
                            begin
                                next_due_next = when;
                            end
                        end
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_SCAN:
            begin
                // read of entry cnt issued, data of entry cnt-1 returns
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cnt_reg[SLOT_W-1:0];
                end
                if (cnt_reg != '0 && key_better)
                begin
                    best_key_next   = key;
                    best_time_next  = ram_rd_data;
                    best_idx_next   = cnt_prev[SLOT_W-1:0];
                    best_found_next = 1'b1;
                end
                if (cnt_reg == CNT_W'(SLOTS))
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DECIDE:
            begin
                if (best_found_reg && best_key_reg <= SIGN_BIT)
                begin
                    state_next = ST_FIRE;
                end
                else
                begin
                    next_due_next = best_found_reg ? best_time_reg : '0;
                    state_next    = ST_FINAL;
                end
            end
            ST_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_fire_next   = 1'b1;
                    out_slot_next   = best_idx_reg;
                    out_time_next   = best_time_reg;
                    out_nd_next     = next_due_reg;
                    out_last_next   = 1'b0;
                    // clear lands before the next pass reads it
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = best_idx_reg;
                    ram_req.wr_data = '0;
                    cnt_next        = '0;
                    best_key_next   = HALF_RANGE ^ SIGN_BIT;
                    best_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_fire_next  = 1'b0;
                    out_slot_next  = '0;
                    out_time_next  = '0;
                    out_nd_next    = next_due_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_due_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_due_reg  <= next_due_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        tv_reg         <= tv_next;
        best_key_reg   <= best_key_next;
        best_time_reg  <= best_time_next;
        best_idx_reg   <= best_idx_next;
        best_found_reg <= best_found_next;
        out_fire_reg   <= out_fire_next;
        out_slot_reg   <= out_slot_next;
        out_time_reg   <= out_time_next;
        out_nd_reg     <= out_nd_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign fire_valid    = out_fire_reg;
    assign fired_slot    = SLOTID_W'(out_slot_reg);
    assign fired_time    = out_time_reg;
    assign next_deadline = out_nd_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/timed_event_scheduler.sv
// timed_event_scheduler: top level, stream ports, slot table and sequencer.
// Depends on tes_pkg, tes_slot_ram, tes_ctrl.
//
// channel   dir   tdata                                      tuser       tlast
// s_axis    in    slot_id, time_value, delay (72 b)          cmd         -
// m_axis    out   fired_slot, fired_time, next_deadline (72) fire_valid  last
//
// Schedule: accept, then final result. Run: accept, then (k+1) table passes
// (read sweep and decide) for k fired slots, one fire result per fired slot and
// the final result; each pass reads one entry a cycle.
// Reset clears the valid bits of the table and next_due at once, no sweep.
// A stalled m_axis holds the result register; a new transaction is taken
// while the last result still waits.
`default_nettype none

module timed_event_scheduler
    import tes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // slot_id[1:0], time_value[33:2], delay[64:34]
    input  wire logic        s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // fired_slot[1:0], fired_time[33:2],
                                             // next_deadline[65:34]
    output logic             m_axis_tuser,   // fire_valid
    output logic             m_axis_tlast    // last
);

    tes_ram_req_t          ram_req;
    logic [TIME_W-1:0]     ram_rd_data;
    logic [SLOTID_W-1:0]   fired_slot;
    logic [TIME_W-1:0]     fired_time;
    logic [TIME_W-1:0]     next_deadline;

    tes_slot_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    tes_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .cmd           (s_axis_tuser),
        .slot_id       (s_axis_tdata[1:0]),
        .time_value    (s_axis_tdata[33:2]),
        .delay         (s_axis_tdata[64:34]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .fire_valid    (m_axis_tuser),
        .fired_slot    (fired_slot),
        .fired_time    (fired_time),
        .next_deadline (next_deadline),
        .last          (m_axis_tlast),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data)
    );

    assign m_axis_tdata = {6'b0, next_deadline, fired_time, fired_slot};

    a_fire_xor_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
        else $error("result is neither a single fire nor a single final");

    a_fired_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2])
        else $error("fired deadline is not a stored deadline");

    a_next_odd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[65:34] != '0) |-> m_axis_tdata[34])
        else $error("next deadline is not a stored deadline");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("transaction accepted while previous one in progress");

endmodule

`default_nettype wire
